FILE: rtl/bat_pkg.sv
`default_nettype none
package bat_pkg;
  localparam int LEVELS = 10;
  localparam int NODES = (1 << (LEVELS + 1)) - 1;
  localparam int NW = LEVELS + 1;
  localparam int SW = 20;
  localparam int IW = 11;
  localparam int LW = $clog2(LEVELS + 1);

  typedef enum logic [1:0] {
    KIND_FREE = 2'd0,
    KIND_DIVIDED = 2'd1,
    KIND_ALLOC = 2'd2
  } kind_t;

  localparam logic [2:0] ST_ALLOC = 3'd0;
  localparam logic [2:0] ST_FREED = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_NOMATCH = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  typedef struct packed {
    logic we;
    logic [NW-1:0] waddr;
    kind_t wkind;
    logic [SW-1:0] wsize;
    logic [NW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    kind_t kind;
    logic [SW-1:0] size;
  } mem_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/buddy_allocator_tree.sv
`default_nettype none
// Order: a rejected request goes straight to the result strobe after the transfer; otherwise an
// allocate scans nodes, checks the ancestors of a free candidate and marks the path up to the root,
// and a free scans for the node, marks it free and checks buddies up the tree, then the result.
// Throughput: one request at a time; busy drops in the cycle that carries the result.
// Reset: first clears the node memory, one entry a cycle (all 2047 nodes), with busy high.
// Results appear for one cycle on done; the receiver cannot stall.
module buddy_allocator_tree (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire logic req_type,
  input wire logic [19:0] request_size,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [19:0] cfg_data,
  output logic done,
  output logic [2:0] status,
  output logic [10:0] node_index,
  output logic [19:0] block_size
);
  import bat_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_SCAN = 10'b0000000100,
    S_SCHK = 10'b0000001000,
    S_ANC = 10'b0000010000,
    S_ACHK = 10'b0000100000,
    S_MARK = 10'b0001000000,
    S_MRD = 10'b0010000000,
    S_MCHK = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state;
  logic [SW-1:0] total_size, req, bsize;
  logic is_free;
  logic [NW-1:0] n, last, cand, walk, found;
  logic [2:0] st_r;
  logic buddy_free;
  mem_req_t mreq;
  mem_rsp_t mrsp;

  bat_node_ram u_ram (.clk(clk), .req(mreq), .rsp(mrsp));

  logic [NW-1:0] parent_w, buddy_w;
  assign parent_w = (walk - NW'(1)) >> 1;
  assign buddy_w = walk[0] ? walk + NW'(1) : walk - NW'(1);

  // level search: count the halvings that still hold the size, up to LEVELS
  logic [LW-1:0] lvl_c;
  logic [SW-1:0] sz_c;
  always_comb begin
    lvl_c = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (request_size <= (total_size >> (i + 1))) lvl_c = lvl_c + LW'(1);
    end
    sz_c = total_size >> lvl_c;
  end

  logic [LW-1:0] dep;
  always_comb begin
    dep = '0;
    for (int i = 1; i <= LEVELS; i++)
      if ({1'b0, found} + (NW+1)'(1) >= (NW+1)'(1 << i)) dep = LW'(i);
  end

  assign busy = state != S_IDLE;
  assign cfg_ready = state == S_IDLE;

  always_comb begin
    mreq = '0;
    mreq.wkind = KIND_FREE;
    unique case (state)
      S_CLEAR: begin
        mreq.we = 1'b1;
        mreq.waddr = n;
      end
      S_SCAN: mreq.raddr = n;
      S_ANC: mreq.raddr = walk;
      S_MARK: begin
        mreq.we = 1'b1;
        mreq.waddr = walk;
        if (is_free) mreq.wkind = KIND_FREE;
        else mreq.wkind = (walk == cand) ? KIND_ALLOC : KIND_DIVIDED;
        mreq.wsize = (!is_free && walk == cand) ? req : '0;
      end
      S_MRD: mreq.raddr = buddy_w;
      S_MCHK: begin
        mreq.we = buddy_free && walk != 0;
        mreq.waddr = parent_w;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      n <= '0;
      total_size <= 20'd1024;
    end else begin
      unique case (state)
        S_CLEAR: begin
          n <= n + NW'(1);
          if (n == NW'(NODES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_valid) total_size <= cfg_data;
          if (start) begin
            req <= request_size;
            is_free <= req_type;
            if (request_size == '0) begin
              st_r <= ST_INVALID;
              state <= S_DONE;
            end else if (!req_type) begin
              if (request_size > total_size) begin
                st_r <= ST_NOSPACE;
                state <= S_DONE;
              end else begin
                bsize <= sz_c;
                n <= (NW'(1) << lvl_c) - NW'(1);
                last <= (NW'(1) << lvl_c) - NW'(1) + (NW'(1) << lvl_c) - NW'(1);
                state <= S_SCAN;
              end
            end else begin
              n <= '0;
              last <= NW'(NODES - 1);
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: state <= S_SCHK;
        S_SCHK: begin
          if (!is_free && mrsp.kind == KIND_FREE) begin
            cand <= n;
            walk <= n;
            state <= S_ANC;
            if (n == 0) begin
              state <= S_MARK;
            end else begin
              walk <= (n - NW'(1)) >> 1;
            end
          end else if (is_free && mrsp.kind == KIND_ALLOC && mrsp.size == req) begin
            found <= n;
            walk <= n;
            state <= S_MARK;
          end else if (n == last) begin
            st_r <= is_free ? ST_NOMATCH : ST_NOSPACE;
            state <= S_DONE;
          end else begin
            n <= n + NW'(1);
            state <= S_SCAN;
          end
        end
        S_ANC: state <= S_ACHK;
        S_ACHK: begin
          if (mrsp.kind == KIND_ALLOC) begin
            if (n == last) begin
              st_r <= ST_NOSPACE;
              state <= S_DONE;
            end else begin
              n <= n + NW'(1);
              state <= S_SCAN;
            end
          end else if (walk == 0) begin
            walk <= cand;
            state <= S_MARK;
          end else begin
            walk <= parent_w;
            state <= S_ANC;
          end
        end
        S_MARK: begin
          if (is_free) begin
            // freeing the found node shares the write path of the clear
            state <= S_MRD;
          end else if (walk == 0) begin
            st_r <= ST_ALLOC;
            found <= cand;
            state <= S_DONE;
          end else begin
            walk <= parent_w;
          end
        end
        S_MRD: state <= S_MCHK;
        S_MCHK: begin
          if (buddy_free && walk != 0) begin
            walk <= parent_w;
            state <= S_MRD;
          end else begin
            st_r <= ST_FREED;
            bsize <= total_size >> dep;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          status <= st_r;
          node_index <= (st_r == ST_ALLOC || st_r == ST_FREED) ? found : '0;
          block_size <= (st_r == ST_ALLOC || st_r == ST_FREED) ? bsize : '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the walked node itself is free during the merge; only the buddy is read
  assign buddy_free = mrsp.kind == KIND_FREE;

  assert property (@(posedge clk) disable iff (rst) done |-> $past(state) == S_DONE)
    else $error("result strobe outside completion");
  assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("transfer did not raise busy");
  assert property (@(posedge clk) disable iff (rst) cfg_valid && cfg_ready |=> !done)
    else $error("config write overlapped a result");
endmodule
`default_nettype wire

FILE: rtl/bat_node_ram.sv
`default_nettype none
module bat_node_ram (
  input wire logic clk,
  input wire bat_pkg::mem_req_t req,
  output bat_pkg::mem_rsp_t rsp
);
  import bat_pkg::*;
  logic [1:0] kind_mem [NODES];
  logic [SW-1:0] size_mem [NODES];
  logic [1:0] kq;
  logic [SW-1:0] sq;

  always_ff @(posedge clk) begin
    if (req.we) begin
      kind_mem[req.waddr] <= req.wkind;
      size_mem[req.waddr] <= req.wsize;
    end
    kq <= kind_mem[req.raddr];
    sq <= size_mem[req.raddr];
  end

  always_comb begin
    rsp.kind = kind_t'(kq);
    rsp.size = sq;
  end
endmodule
`default_nettype wire
